// File: hw/rtl/amt_pkg.sv
package amt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int NUM_CORNERS   = 8;
  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;

  // Pipeline depths of the individual units.
  localparam int XF_LAT    = 3;
  localparam int DIV_QBITS = 32;
  localparam int DIV_LAT   = DIV_QBITS + 2;
  localparam int MM_LAT    = 3;
  localparam int SIDE_LAT  = XF_LAT + DIV_LAT + MM_LAT;
  localparam int LATENCY   = SIDE_LAT + 2;

  // Matrix as [row][column] of 32-bit two's complement elements.
  typedef logic [3:0][3:0][31:0] mat_t;

  // Transformed corners as [corner][column].
  typedef logic [NUM_CORNERS-1:0][3:0][31:0] corner_t;

  typedef struct packed {
    logic            inf;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } box_t;

endpackage

// File: hw/rtl/aabb_matrix_transform.sv
// Bounding box transform: takes one axis-aligned box and returns the box that
// bounds its image under a 4x4 matrix, in signed fixed point.
// Input transactions are issued with start; one is accepted at every rising
// edge where start is high and busy is low. Busy never rises, so a new box
// can be issued in every cycle and the sustained rate is one box per cycle.
// Each accepted box yields exactly one result, shown for one cycle with done
// high. The depth is set by the pipelined dividers: one quotient bit per stage
// for 32 bits, plus a setup and a saturation stage. The remaining stages are
// input registers, three stages of multiply, scale and sum, a three level
// min/max tree and the output register.
// The matrix is written over the APB port, two 32-bit elements per 64-bit
// register at byte address 8*i, and must only change while no transaction
// is in flight. Reset loads the identity matrix and drops every transaction
// in flight. The receiver cannot hold results off, so none is needed.
module aabb_matrix_transform import amt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               box_is_infinite,
  input  logic signed [31:0] lo_x,
  input  logic signed [31:0] lo_y,
  input  logic signed [31:0] lo_z,
  input  logic signed [31:0] hi_x,
  input  logic signed [31:0] hi_y,
  input  logic signed [31:0] hi_z,
  output logic               done,
  output logic               out_is_infinite,
  output logic signed [31:0] out_lo_x,
  output logic signed [31:0] out_lo_y,
  output logic signed [31:0] out_lo_z,
  output logic signed [31:0] out_hi_x,
  output logic signed [31:0] out_hi_y,
  output logic signed [31:0] out_hi_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  mat_t              mat;
  logic              accept;
  logic [LATENCY-1:0] vld;
  box_t              a_box;
  box_t              side [SIDE_LAT];
  corner_t           t;
  logic [2:0][NUM_CORNERS-1:0][31:0] quo;
  logic [2:0][31:0]  mm_lo, mm_hi;

  // The pipeline never stalls, so it is always ready for a transaction.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[LATENCY-1];

  amt_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .mat(mat)
  );

  // Valid bits travel with the data; no other datapath state is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    a_box.inf <= box_is_infinite;
    a_box.lo  <= {lo_z, lo_y, lo_x};
    a_box.hi  <= {hi_z, hi_y, hi_x};
  end

  // The original box rides along so an infinite box can be passed through.
  always_ff @(posedge clk) begin
    side[0] <= a_box;
    for (int j = 1; j < SIDE_LAT; j++) begin
      side[j] <= side[j-1];
    end
  end

  amt_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk), .lo(a_box.lo), .hi(a_box.hi), .mat(mat), .t(t)
  );

  // One divider per corner and axis; column 3 of each corner is its w.
  for (genvar i = 0; i < NUM_CORNERS; i++) begin : g_corner
    for (genvar c = 0; c < 3; c++) begin : g_axis
      amt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .n(t[i][c]), .w(t[i][3]), .q(quo[c][i])
      );
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_mm
    amt_minmax u_mm (.clk(clk), .v(quo[c]), .lo(mm_lo[c]), .hi(mm_hi[c]));
  end

  always_ff @(posedge clk) begin
    out_is_infinite <= side[SIDE_LAT-1].inf;
    if (side[SIDE_LAT-1].inf) begin
      {out_lo_z, out_lo_y, out_lo_x} <= side[SIDE_LAT-1].lo;
      {out_hi_z, out_hi_y, out_hi_x} <= side[SIDE_LAT-1].hi;
    end else begin
      {out_lo_z, out_lo_y, out_lo_x} <= mm_lo;
      {out_hi_z, out_hi_y, out_hi_x} <= mm_hi;
    end
  end

endmodule

// File: hw/rtl/amt_cfg.sv
module amt_cfg import amt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output mat_t              mat
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0] regs [NUM_REGS];
  logic [2:0]        idx;

  assign idx    = paddr[ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= ONE;
      regs[1] <= '0;
      regs[2] <= ONE << 32;
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= ONE;
      regs[6] <= '0;
      regs[7] <= ONE << 32;
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata;
    end
  end

  // Each register holds two adjacent columns of one row.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        mat[r][c] = regs[2 * r + c / 2][(c % 2) * 32 +: 32];
      end
    end
  end

endmodule

// File: hw/rtl/amt_xform.sv
module amt_xform import amt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic [2:0][31:0] lo,
  input  logic [2:0][31:0] hi,
  input  mat_t             mat,
  output corner_t          t
);

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Only two coordinate values exist per axis, so 24 products cover all corners.
  logic signed [63:0] prod [3][2][4];
  logic [31:0]        scl  [3][2][4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        prod[k][0][c] <= $signed(lo[k]) * $signed(mat[k][c]);
        prod[k][1][c] <= $signed(hi[k]) * $signed(mat[k][c]);
      end
    end
  end

  // Arithmetic shift gives the floor, which is the required rounding.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int s = 0; s < 2; s++) begin
        for (int c = 0; c < 4; c++) begin
          scl[k][s][c] <= sat64(prod[k][s][c] >>> FRAC_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      for (int c = 0; c < 4; c++) begin
        t[i][c] <= sat34(34'($signed(scl[0][(i >> 2) & 1][c]))
                       + 34'($signed(scl[1][(i >> 1) & 1][c]))
                       + 34'($signed(scl[2][i & 1][c]))
                       + 34'($signed(mat[3][c])));
      end
    end
  end

endmodule

// File: hw/rtl/amt_div.sv
module amt_div import amt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic [31:0] n,
  input  logic [31:0] w,
  output logic [31:0] q
);

  localparam int NW = 32 + FRAC_BITS;

  logic [NW-1:0]        rem [DIV_QBITS+1];
  logic [31:0]          dv  [DIV_QBITS+1];
  logic [DIV_QBITS-1:0] qv  [DIV_QBITS+1];
  logic                 neg [DIV_QBITS+1];
  logic                 ovf [DIV_QBITS+1];
  logic                 zr  [DIV_QBITS+1];

  logic [31:0]   nabs;
  logic [31:0]   wabs;
  logic [NW-1:0] num;

  assign nabs = n[31] ? (32'd0 - n) : n;
  assign wabs = w[31] ? (32'd0 - w) : w;
  assign num  = {nabs, FRAC_BITS'(0)};

  // Quotients of 2^32 or more in magnitude (w of zero, n nonzero) saturate.
  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= wabs;
    qv[0]  <= '0;
    neg[0] <= n[31] ^ w[31];
    zr[0]  <= (n == 32'd0);
    ovf[0] <= (64'(num) >= (64'(wabs) << 32));
  end

  for (genvar j = 0; j < DIV_QBITS; j++) begin : g_iter
    localparam int B = DIV_QBITS - 1 - j;
    logic [63:0] trial;
    logic        fit;
    assign trial = 64'(dv[j]) << B;
    assign fit   = (64'(rem[j]) >= trial);

    always_ff @(posedge clk) begin
      rem[j+1] <= fit ? NW'(64'(rem[j]) - trial) : rem[j];
      qv[j+1]  <= qv[j] | (DIV_QBITS'(fit) << B);
      dv[j+1]  <= dv[j];
      neg[j+1] <= neg[j];
      ovf[j+1] <= ovf[j];
      zr[j+1]  <= zr[j];
    end
  end

  always_ff @(posedge clk) begin
    if (zr[DIV_QBITS]) begin
      q <= '0;
    end else if (ovf[DIV_QBITS]) begin
      q <= neg[DIV_QBITS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg[DIV_QBITS]) begin
      q <= (qv[DIV_QBITS] > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - qv[DIV_QBITS]);
    end else begin
      q <= (qv[DIV_QBITS] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv[DIV_QBITS];
    end
  end

endmodule

// File: hw/rtl/amt_minmax.sv
module amt_minmax import amt_pkg::*; (
  input  logic                        clk,
  input  logic [NUM_CORNERS-1:0][31:0] v,
  output logic [31:0]                 lo,
  output logic [31:0]                 hi
);

  logic [3:0][31:0] lo1, hi1;
  logic [1:0][31:0] lo2, hi2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if ($signed(v[2*i]) < $signed(v[2*i+1])) begin
        lo1[i] <= v[2*i];
        hi1[i] <= v[2*i+1];
      end else begin
        lo1[i] <= v[2*i+1];
        hi1[i] <= v[2*i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      lo2[i] <= ($signed(lo1[2*i]) < $signed(lo1[2*i+1])) ? lo1[2*i] : lo1[2*i+1];
      hi2[i] <= ($signed(hi1[2*i]) > $signed(hi1[2*i+1])) ? hi1[2*i] : hi1[2*i+1];
    end
    lo <= ($signed(lo2[0]) < $signed(lo2[1])) ? lo2[0] : lo2[1];
    hi <= ($signed(hi2[0]) > $signed(hi2[1])) ? hi2[0] : hi2[1];
  end

endmodule

// File: hw/rtl/amt_checker.sv
module amt_checker import amt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               box_is_infinite,
  input logic signed [31:0] lo_x,
  input logic signed [31:0] hi_x,
  input logic               done,
  input logic               out_is_infinite,
  input logic signed [31:0] out_lo_x,
  input logic signed [31:0] out_lo_y,
  input logic signed [31:0] out_lo_z,
  input logic signed [31:0] out_hi_x,
  input logic signed [31:0] out_hi_y,
  input logic signed [31:0] out_hi_z
);

  // Every accepted transaction produces its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("missing result for an accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  a_inf_pass: assert property (@(posedge clk) disable iff (rst)
    done && $past(box_is_infinite, LATENCY) |->
      out_is_infinite && out_lo_x == $past(lo_x, LATENCY)
      && out_hi_x == $past(hi_x, LATENCY))
    else $error("infinite box not passed through");

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    done && !out_is_infinite |->
      out_lo_x <= out_hi_x && out_lo_y <= out_hi_y && out_lo_z <= out_hi_z)
    else $error("bounding box minimum above maximum");

endmodule

bind aabb_matrix_transform amt_checker u_amt_checker (.*);

// File: tb/tb_aabb_matrix_transform.sv
// Self-checking bench for the bounding box transform block.
// A predictor kept inside the bench mirrors the matrix registers and works out
// the transformed box for every accepted transaction. A monitor compares each
// result, marked by done, with the oldest pending prediction field by field.
module tb_aabb_matrix_transform;
  import amt_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  // Register indexes of the matrix halves (byte address is 8 * index).
  localparam int REG_R0_A = 0;
  localparam int REG_R0_B = 1;
  localparam int REG_R1_A = 2;
  localparam int REG_R1_B = 3;
  localparam int REG_R2_A = 4;
  localparam int REG_R2_B = 5;
  localparam int REG_R3_A = 6;
  localparam int REG_R3_B = 7;

  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic box_is_infinite;
  logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic done;
  logic out_is_infinite;
  logic signed [31:0] out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  aabb_matrix_transform DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .box_is_infinite(box_is_infinite),
    .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
    .done(done), .out_is_infinite(out_is_infinite),
    .out_lo_x(out_lo_x), .out_lo_y(out_lo_y), .out_lo_z(out_lo_z),
    .out_hi_x(out_hi_x), .out_hi_y(out_hi_y), .out_hi_z(out_hi_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the matrix registers, updated with every bus write.
  logic [63:0] matrix_shadow [NUM_REGS];
  // Boxes the block is expected to return, oldest first.
  box_t expected_boxes [$];
  int   error_count;
  int   boxes_sent;
  int   boxes_checked;
  int   infinite_sent;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung pipeline or a lost transaction ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return Q_MAX;
    if (v < -longint'(64'h8000_0000)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] matrix_elem(int row, int col);
    logic [63:0] r;
    r = matrix_shadow[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  // Fixed-point product: exact, then floored by the fraction width, saturated.
  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> FRAC);
  endfunction

  // Perspective divide; a zero w saturates toward the sign of the numerator.
  function automatic logic signed [31:0] fx_div(logic signed [31:0] n,
                                                logic signed [31:0] w);
    longint num;
    if (w == 0) begin
      if (n > 0) return Q_MAX;
      if (n < 0) return Q_MIN;
      return '0;
    end
    num = longint'(n) <<< FRAC;
    return sat32(num / longint'(w));
  endfunction

  // Keeps per-axis extremes of all eight transformed corners; inf boxes pass.
  function automatic box_t transform_box(box_t b);
    box_t r;
    logic signed [31:0] pt [3];
    logic signed [31:0] t [4];
    logic signed [31:0] v;
    longint s;
    r = b;
    if (b.inf) return r;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      pt[0] = i[2] ? b.hi[0] : b.lo[0];
      pt[1] = i[1] ? b.hi[1] : b.lo[1];
      pt[2] = i[0] ? b.hi[2] : b.lo[2];
      for (int c = 0; c < 4; c++) begin
        s = longint'(fx_mul(pt[0], matrix_elem(0, c))) +
            longint'(fx_mul(pt[1], matrix_elem(1, c))) +
            longint'(fx_mul(pt[2], matrix_elem(2, c))) +
            longint'(matrix_elem(3, c));
        t[c] = sat32(s);
      end
      for (int c = 0; c < 3; c++) begin
        v = fx_div(t[c], t[3]);
        if (i == 0 || v < $signed(r.lo[c])) r.lo[c] = v;
        if (i == 0 || v > $signed(r.hi[c])) r.hi[c] = v;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result monitor. Outputs are sampled at the edge that ends the done cycle.
  always @(posedge clk) begin
    box_t e;
    if (!rst && done) begin
      if (expected_boxes.size() == 0) begin
        $error("result arrived with no transaction pending");
        error_count++;
      end else begin
        e = expected_boxes.pop_front();
        boxes_checked++;
        check_field("out_is_infinite", {31'b0, e.inf}, {31'b0, out_is_infinite});
        check_field("out_lo_x", e.lo[0], out_lo_x);
        check_field("out_lo_y", e.lo[1], out_lo_y);
        check_field("out_lo_z", e.lo[2], out_lo_z);
        check_field("out_hi_x", e.hi[0], out_hi_x);
        check_field("out_hi_y", e.hi[1], out_hi_y);
        check_field("out_hi_z", e.hi[2], out_hi_z);
      end
    end
  end

  // Called right after a rising edge. Start is left high so back-to-back
  // transactions follow with no gap; the caller lowers it for gaps.
  task automatic send_box(box_t b);
    start           <= 1'b1;
    box_is_infinite <= b.inf;
    lo_x <= b.lo[0]; lo_y <= b.lo[1]; lo_z <= b.lo[2];
    hi_x <= b.hi[0]; hi_y <= b.hi[1]; hi_z <= b.hi[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_boxes.push_back(transform_box(b));
    boxes_sent++;
    if (b.inf) infinite_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Lets the pipeline empty before the matrix may change.
  task automatic drain;
    idle_cycles(1);
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // The bus returns to idle after every write.
  task automatic write_reg(int idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    matrix_shadow[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [31:0] m [4][4]);
    write_reg(REG_R0_A, {m[0][1], m[0][0]});
    write_reg(REG_R0_B, {m[0][3], m[0][2]});
    write_reg(REG_R1_A, {m[1][1], m[1][0]});
    write_reg(REG_R1_B, {m[1][3], m[1][2]});
    write_reg(REG_R2_A, {m[2][1], m[2][0]});
    write_reg(REG_R2_B, {m[2][3], m[2][2]});
    write_reg(REG_R3_A, {m[3][1], m[3][0]});
    write_reg(REG_R3_B, {m[3][3], m[3][2]});
  endtask

  function automatic box_t make_box(logic inf, logic [31:0] lx, logic [31:0] ly,
                                    logic [31:0] lz, logic [31:0] hx,
                                    logic [31:0] hy, logic [31:0] hz);
    box_t b;
    b.inf = inf;
    b.lo[0] = lx; b.lo[1] = ly; b.lo[2] = lz;
    b.hi[0] = hx; b.hi[1] = hy; b.hi[2] = hz;
    return b;
  endfunction

  // Coordinates are mostly modest so the matrix math stays out of saturation,
  // with some full-range values to exercise the clamps.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    logic [31:0] a, c;
    b.inf = ($urandom_range(0, 15) == 0);
    for (int k = 0; k < 3; k++) begin
      a = rand_coord();
      c = rand_coord();
      // Mostly ordered boxes; some are left inverted on purpose.
      if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(c)) begin
        b.lo[k] = c; b.hi[k] = a;
      end else begin
        b.lo[k] = a; b.hi[k] = c;
      end
    end
    return b;
  endfunction

  // Random matrix; style selects affine, projective or unrestricted content.
  task automatic load_random_matrix(int style);
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        case (style)
          0: m[r][c] = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
          1: m[r][c] = 32'($signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000);
          default: m[r][c] = $urandom();
        endcase
      end
    if (style == 0) begin
      // Affine: w column is 0,0,0,1.
      m[0][3] = '0; m[1][3] = '0; m[2][3] = '0; m[3][3] = Q_ONE;
    end else if (style == 1) begin
      m[3][3] = 32'($signed($urandom_range(0, 32'h0004_0000)) + 32'sh0000_8000);
    end
    load_matrix(m);
  endtask

  // Sends n random boxes in bursts; with gaps off the stream is gapless.
  task automatic send_random_stream(int n, bit gaps);
    int burst;
    burst = $urandom_range(1, 24);
    for (int k = 0; k < n; k++) begin
      send_box(rand_box());
      burst--;
      if (gaps && burst == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  // Identity matrix from reset: extreme coordinates, inverted boxes and
  // infinite boxes carrying arbitrary payloads.
  task automatic test_identity_edges;
    send_box(make_box(1'b0, '0, '0, '0, '0, '0, '0));
    send_box(make_box(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
    send_box(make_box(1'b0, 32'hFFFF_FFFF, Q_ONE, 32'hFFFF_0000, Q_ONE, 32'h0, 32'h1));
    send_box(make_box(1'b1, Q_MAX, Q_MIN, 32'h1234_5678, Q_MIN, Q_MAX, 32'hDEAD_BEEF));
    send_box(make_box(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_box(make_box(1'b0, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
                      32'hFFFF_8000, 32'h0002_0000, 32'hFFFE_0000));
    drain();
  endtask

  // A zero w column: the divide must clamp by the numerator's sign.
  task automatic test_zero_w;
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? Q_ONE : '0;
    m[3][3] = '0;
    load_matrix(m);
    send_box(make_box(1'b0, 32'h0001_0000, 32'hFFFF_0000, '0,
                      32'h0002_0000, 32'h0000_0000, 32'h0001_0000));
    send_box(make_box(1'b0, '0, '0, '0, '0, '0, '0));
    send_box(make_box(1'b0, Q_MIN, 32'h5, 32'hFFFF_FFFB, Q_MAX, 32'h5, 32'hFFFF_FFFB));
    drain();
  endtask

  // Extreme matrix elements drive products and sums into saturation, and
  // the negative w of the second matrix flips the ordering of the corners.
  task automatic test_saturation;
    logic [31:0] m [4][4];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = ((r + c) % 2) ? Q_MIN : Q_MAX;
    load_matrix(m);
    send_box(make_box(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(1'b0, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                      32'h0000_0002, 32'h0001_0000, '0));
    send_box(make_box(1'b0, '0, '0, '0, '0, '0, '0));
    drain();
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? 32'hFFFF_0000 : 32'h0000_0001;
    m[3][0] = Q_MAX; m[3][1] = Q_MIN;
    load_matrix(m);
    send_box(make_box(1'b0, 32'h0010_0000, 32'hFFF0_0000, 32'h1, Q_MAX, Q_MAX, Q_MAX));
    send_box(make_box(1'b0, Q_MIN, 32'h8000_0001, Q_MIN, 32'h0, 32'h1, 32'h0));
    drain();
  endtask

  // Random phases over affine, projective and unrestricted matrices.
  task automatic test_random_phases;
    for (int ph = 0; ph < 9; ph++) begin
      load_random_matrix(ph % 3);
      send_random_stream(104, ph != 4);
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    box_is_infinite = 1'b0;
    lo_x = '0; lo_y = '0; lo_z = '0; hi_x = '0; hi_y = '0; hi_z = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    error_count = 0; boxes_sent = 0; boxes_checked = 0; infinite_sent = 0;
    cycle_count = 0;
    // Reset contents: the identity matrix.
    for (int k = 0; k < NUM_REGS; k++) matrix_shadow[k] = '0;
    matrix_shadow[REG_R0_A] = {32'h0, Q_ONE};
    matrix_shadow[REG_R1_A] = {Q_ONE, 32'h0};
    matrix_shadow[REG_R2_B] = {32'h0, Q_ONE};
    matrix_shadow[REG_R3_B] = {Q_ONE, 32'h0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_edges();
    test_zero_w();
    test_saturation();
    test_random_phases();

    $display("Checked %0d of %0d boxes (%0d infinite) across identity, zero-w,",
             boxes_checked, boxes_sent, infinite_sent);
    $display("saturating and random affine/projective matrices.");
    if (error_count == 0 && expected_boxes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
